// File: rtl/vsa_pkg.sv
// Package with the shared constants, controller states and command/status types.
`timescale 1ns / 1ps
`default_nettype none

package vsa_pkg;

    localparam int COORD_W   = 8;
    localparam int PW        = COORD_W + 2;
    localparam int GRID_W    = 7;
    localparam int EFF_W     = 8;
    localparam int OUT_CNT_W = 16;
    localparam int ADD_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_READ   = 9'b000001000,
        S_RDATA  = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_ADV    = 9'b001000000,
        S_TEST   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_start;
        logic cap_count;
        logic wr_bump;
        logic advance;
        logic out_load;
    } vsa_cmd_t;

    typedef struct packed {
        logic is_read;
        logic p_in;
        logic e_in;
        logic at_end;
        logic walk_done;
        logic clr_last;
    } vsa_sts_t;

endpackage

`default_nettype wire

// File: rtl/vsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/vsa_ctrl.sv
// Controller state machine that sequences clearing, reads and the voxel walk.
`timescale 1ns / 1ps
`default_nettype none

module vsa_ctrl
    import vsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  vsa_sts_t sts,
    output vsa_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_read)
                begin
                    state_next = sts.p_in ? S_READ : S_OUT;
                end
                else if (!(sts.p_in || sts.e_in))
                begin
                    state_next = S_OUT;
                end
                else if (sts.p_in)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_READ:
            begin
                cmd.rd_start = 1'b1;
                state_next   = sts.is_read ? S_RDATA : S_WRITE;
            end
            S_RDATA:
            begin
                cmd.cap_count = 1'b1;
                state_next    = S_OUT;
            end
            S_WRITE:
            begin
                cmd.wr_bump = 1'b1;
                if (sts.at_end || sts.walk_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_TEST;
                end
            end
            S_ADV:
            begin
                if (sts.at_end || sts.walk_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_TEST;
                end
            end
            S_TEST:
            begin
                state_next = sts.p_in ? S_READ : S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result only appears out of the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the result state");

    // Requests are only taken while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("request taken outside the idle state");

    // A pending result stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped before it was taken");

endmodule

`default_nettype wire

// File: rtl/vsa_dp.sv
// Datapath: grid registers, walk registers, exact boundary compare and count store.
`timescale 1ns / 1ps
`default_nettype none

module vsa_dp
    import vsa_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vsa_cmd_t                    cmd,
    output vsa_sts_t                    sts,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [GRID_W-1:0]           cfg_data,
    input  logic                        req_type,
    input  logic signed [COORD_W-1:0]   start_x,
    input  logic signed [COORD_W-1:0]   start_y,
    input  logic signed [COORD_W-1:0]   start_z,
    input  logic signed [COORD_W-1:0]   end_x,
    input  logic signed [COORD_W-1:0]   end_y,
    input  logic signed [COORD_W-1:0]   end_z,
    output logic [OUT_CNT_W-1:0]        voxel_count,
    output logic [ADD_W-1:0]            voxels_added,
    output logic [OUT_CNT_W-1:0]        peak_count
);

    localparam int DEPTH      = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW         = $clog2(DEPTH);
    localparam int CIW        = $clog2(MAX_DIM);
    localparam int WALK_LIMIT = 3 * MAX_DIM;
    localparam int GW         = $clog2(WALK_LIMIT + 1);
    localparam int CW         = $clog2((WALK_LIMIT + 1) * 255 + 1);
    localparam int CMP_W      = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [GRID_W-1:0]          grid_reg [3];
    logic [EFF_W-1:0]           eff [3];
    logic signed [COORD_W-1:0]  start_v [3];
    logic signed [COORD_W-1:0]  end_v [3];
    logic signed [COORD_W:0]    d [3];
    logic [COORD_W:0]           d_abs [3];
    logic signed [PW-1:0]       p_reg [3];
    logic signed [PW-1:0]       e_reg [3];
    logic signed [PW-1:0]       delta [3];
    logic [COORD_W-1:0]         den_reg [3];
    logic                       pos_reg [3];
    logic [CW-1:0]              c01_reg, c02_reg, c10_reg, c12_reg, c20_reg, c21_reg;
    logic                       e01, e02, e12;
    logic [1:0]                 ax;
    logic                       req_reg;
    logic [GW-1:0]              guard_reg;
    logic [ADD_W-1:0]           added_reg;
    logic [OUT_CNT_W-1:0]       count_reg;
    logic [COUNT_BITS-1:0]      peak_reg;
    logic [AW-1:0]              clr_reg;
    logic [AW-1:0]              addr_reg;
    logic [AW-1:0]              addr_c;
    logic [COUNT_BITS-1:0]      rdata;
    logic [COUNT_BITS-1:0]      inc;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [COUNT_BITS-1:0]      mem_wdata;
    logic [OUT_CNT_W-1:0]       out_count_reg;
    logic [ADD_W-1:0]           out_added_reg;
    logic [OUT_CNT_W-1:0]       out_peak_reg;

    function automatic logic in_grid(input logic signed [PW-1:0] v,
                                     input logic [EFF_W-1:0] lim);
        return !v[PW-1] && ({1'b0, v[PW-2:0]} < {2'b0, lim});
    endfunction

    function automatic logic earlier(input logic [COORD_W-1:0] den_i,
                                     input logic [COORD_W-1:0] den_j,
                                     input logic [CW-1:0] c_ij,
                                     input logic [CW-1:0] c_ji);
        if (den_i == '0)
        begin
            return 1'b0;
        end
        if (den_j == '0)
        begin
            return 1'b1;
        end
        return c_ij < c_ji;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide > CMP_W'({OUT_CNT_W{1'b1}}))
        begin
            return {OUT_CNT_W{1'b1}};
        end
        return wide[OUT_CNT_W-1:0];
    endfunction

    assign start_v[0] = start_x;
    assign start_v[1] = start_y;
    assign start_v[2] = start_z;
    assign end_v[0]   = end_x;
    assign end_v[1]   = end_y;
    assign end_v[2]   = end_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eff[i]   = (EFF_W'(grid_reg[i]) > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM)
                                                              : EFF_W'(grid_reg[i]);
            d[i]     = (COORD_W + 1)'(end_v[i]) - (COORD_W + 1)'(start_v[i]);
            d_abs[i] = d[i][COORD_W] ? (COORD_W + 1)'(-d[i]) : (COORD_W + 1)'(d[i]);
            if (den_reg[i] == '0)
            begin
                delta[i] = '0;
            end
            else
            begin
                delta[i] = pos_reg[i] ? PW'(1) : -PW'(1);
            end
        end
    end

    // Ties go to Y over X and to Z over both.
    always_comb
    begin
        e01 = earlier(den_reg[0], den_reg[1], c01_reg, c10_reg);
        e02 = earlier(den_reg[0], den_reg[2], c02_reg, c20_reg);
        e12 = earlier(den_reg[1], den_reg[2], c12_reg, c21_reg);
        if (e01)
        begin
            ax = e02 ? AX_X : AX_Z;
        end
        else
        begin
            ax = e12 ? AX_Y : AX_Z;
        end
    end

    assign addr_c = AW'(p_reg[0][CIW-1:0]) * AW'(MAX_DIM * MAX_DIM)
                  + AW'(p_reg[1][CIW-1:0]) * AW'(MAX_DIM)
                  + AW'(p_reg[2][CIW-1:0]);

    assign inc = (rdata == CNT_MAX) ? rdata : rdata + COUNT_BITS'(1);

    assign mem_we    = cmd.clr_en || cmd.wr_bump;
    assign mem_waddr = cmd.clr_en ? clr_reg : addr_reg;
    assign mem_wdata = cmd.clr_en ? '0 : inc;

    vsa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.rd_start),
        .raddr (addr_c),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                grid_reg[i] <= GRID_RESET;
            end
            guard_reg <= '0;
            added_reg <= '0;
            peak_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GRID_X: grid_reg[0] <= cfg_data;
                    CFG_GRID_Y: grid_reg[1] <= cfg_data;
                    CFG_GRID_Z: grid_reg[2] <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                guard_reg <= '0;
                added_reg <= '0;
            end
            if (cmd.advance)
            begin
                guard_reg <= guard_reg + GW'(1);
            end
            if (cmd.wr_bump)
            begin
                if (added_reg != {ADD_W{1'b1}})
                begin
                    added_reg <= added_reg + ADD_W'(1);
                end
                if (inc > peak_reg)
                begin
                    peak_reg <= inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            count_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]   <= PW'(start_v[i]);
                e_reg[i]   <= PW'(end_v[i]);
                den_reg[i] <= d_abs[i][COORD_W-1:0];
                pos_reg[i] <= !d[i][COORD_W] && (d[i] != '0);
            end
            c01_reg <= (!d[0][COORD_W] && d[0] != '0) ? CW'(d_abs[1][COORD_W-1:0]) : '0;
            c02_reg <= (!d[0][COORD_W] && d[0] != '0) ? CW'(d_abs[2][COORD_W-1:0]) : '0;
            c10_reg <= (!d[1][COORD_W] && d[1] != '0) ? CW'(d_abs[0][COORD_W-1:0]) : '0;
            c12_reg <= (!d[1][COORD_W] && d[1] != '0) ? CW'(d_abs[2][COORD_W-1:0]) : '0;
            c20_reg <= (!d[2][COORD_W] && d[2] != '0) ? CW'(d_abs[0][COORD_W-1:0]) : '0;
            c21_reg <= (!d[2][COORD_W] && d[2] != '0) ? CW'(d_abs[1][COORD_W-1:0]) : '0;
        end
        if (cmd.advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (ax == 2'(i))
                begin
                    p_reg[i] <= p_reg[i] + delta[i];
                end
            end
            case (ax)
                AX_X:
                begin
                    c01_reg <= c01_reg + CW'(den_reg[1]);
                    c02_reg <= c02_reg + CW'(den_reg[2]);
                end
                AX_Y:
                begin
                    c10_reg <= c10_reg + CW'(den_reg[0]);
                    c12_reg <= c12_reg + CW'(den_reg[2]);
                end
                AX_Z:
                begin
                    c20_reg <= c20_reg + CW'(den_reg[0]);
                    c21_reg <= c21_reg + CW'(den_reg[1]);
                end
                default:
                begin
                    c01_reg <= c01_reg;
                end
            endcase
        end
        if (cmd.rd_start)
        begin
            addr_reg <= addr_c;
        end
        if (cmd.cap_count)
        begin
            count_reg <= clamp_out(rdata);
        end
        if (cmd.out_load)
        begin
            out_count_reg <= count_reg;
            out_added_reg <= added_reg;
            out_peak_reg  <= clamp_out(peak_reg);
        end
    end

    assign sts.is_read   = (req_reg == REQ_READ);
    assign sts.p_in      = in_grid(p_reg[0], eff[0]) && in_grid(p_reg[1], eff[1])
                        && in_grid(p_reg[2], eff[2]);
    assign sts.e_in      = in_grid(e_reg[0], eff[0]) && in_grid(e_reg[1], eff[1])
                        && in_grid(e_reg[2], eff[2]);
    assign sts.at_end    = (p_reg[0] == e_reg[0]) && (p_reg[1] == e_reg[1])
                        && (p_reg[2] == e_reg[2]);
    assign sts.walk_done = (guard_reg == GW'(WALK_LIMIT));
    assign sts.clr_last  = (clr_reg == AW'(DEPTH - 1));

    assign voxel_count  = out_count_reg;
    assign voxels_added = out_added_reg;
    assign peak_count   = out_peak_reg;

    // Every count update writes back the value read in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_bump |-> $past(cmd.rd_start))
        else $error("count written without a preceding read");

    // The largest count only grows.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak count decreased");

    // The walk never steps off the end voxel or past its step bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !sts.at_end && !sts.walk_done)
        else $error("walk stepped after its end");

endmodule

`default_nettype wire

// File: rtl/voxel_segment_accumulator_top.sv
// Top level of the voxel segment accumulator: controller, datapath and ports.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   req_type, start_x/y/z, end_x/y/z
//  out      out_valid / out_ready voxel_count, voxels_added, peak_count
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset the count memory is cleared one entry per cycle, all MAX_DIM^3 entries
// (262144 at the default), and no request is accepted until that finishes.
// A read request inside the grid passes the decide, read, read-data and result states;
// one outside the grid, or a segment with both ends outside, goes from decide to result.
// A segment passes each counted voxel through the read, write and test states, a
// read-modify-write of each count through the single count memory.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module voxel_segment_accumulator_top
    import vsa_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] start_z,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    input  logic signed [COORD_W-1:0] end_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OUT_CNT_W-1:0]      voxel_count,
    output logic [ADD_W-1:0]          voxels_added,
    output logic [OUT_CNT_W-1:0]      peak_count,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GRID_W-1:0]         cfg_data
);

    vsa_cmd_t cmd;
    vsa_sts_t sts;

    assign cfg_ready = 1'b1;

    vsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vsa_dp #(
        .MAX_DIM    (MAX_DIM),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .voxel_count  (voxel_count),
        .voxels_added (voxels_added),
        .peak_count   (peak_count)
    );

endmodule

`default_nettype wire
